@@ rtl/polynomial_eval_with_derivatives_defines.svh @@
// ----------------------------------------------------------------------------
// polynomial_eval_with_derivatives_defines.svh
// Assertion macros for the polynomial evaluator. Empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_EVAL_WITH_DERIVATIVES_DEFINES_SVH
`define POLYNOMIAL_EVAL_WITH_DERIVATIVES_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define PEV_CHECK_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pev: assertion failed");

// next-cycle implication
`define PEV_CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pev: assertion failed");

`else

`define PEV_CHECK_IMP(lbl, clk, rst_n, ante, cons)
`define PEV_CHECK_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/pev_pkg.sv @@
// ----------------------------------------------------------------------------
// pev_pkg
// Shared constants, types and helpers of the polynomial evaluator.
// ----------------------------------------------------------------------------
package pev_pkg;

    localparam int NUM_COEFFS = 6;
    localparam int MAX_ORDER  = NUM_COEFFS - 1;
    localparam int ORD_W      = 3;
    localparam int COEF_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int FACT_W     = 6;
    // coefficient times derivative factor (at most 20)
    localparam int SCOEF_W    = COEF_W + 5;
    // bits needed by the exact Horner sum, plus headroom for the term count
    localparam int ACC_NEED   = SCOEF_W + (COEF_W - 1) * MAX_ORDER + 3;
    localparam int CHUNK_W    = 32;
    localparam int NCHUNK     = (ACC_NEED + CHUNK_W - 1) / CHUNK_W;
    localparam int ACC_W      = NCHUNK * CHUNK_W;
    localparam int ACC_SH_W   = $clog2(ACC_W);
    localparam int PP_W       = 2 * CHUNK_W + 1;
    localparam int K_W        = $clog2(NCHUNK + 1);
    localparam int CI_W       = $clog2(NUM_COEFFS);
    localparam int SH_W       = ORD_W + 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef logic [1:0] t_deriv;
    localparam t_deriv D_VALUE = 2'd0;
    localparam t_deriv D_SLOPE = 2'd1;
    localparam t_deriv D_CURV  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF0 = 3'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_STEP,
        S_MUL,
        S_ROUND,
        S_DONE
    } t_state;

    // coefficient of x^j in the d-th derivative
    function automatic logic signed [SCOEF_W-1:0] scale_coef(
        input logic signed [COEF_W-1:0] c,
        input logic [ORD_W-1:0]         j,
        input t_deriv                   d
    );
        logic [FACT_W-1:0] f;
        logic [FACT_W-1:0] j1;
        logic [FACT_W-1:0] j2;
        j1 = FACT_W'(j) + FACT_W'(1);
        j2 = FACT_W'(j) + FACT_W'(2);
        case (d)
            D_SLOPE: f = j1;
            D_CURV:  f = FACT_W'(j2 * j1);
            default: f = FACT_W'(1);
        endcase
        return SCOEF_W'(c) * SCOEF_W'($signed({1'b0, f}));
    endfunction

endpackage

@@ rtl/pev_in_if.sv @@
// ----------------------------------------------------------------------------
// pev_in_if
// Input channel: one abscissa per item, valid/ready.
// ----------------------------------------------------------------------------
interface pev_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pev_pkg::COEF_W-1:0]  abscissa;

    modport source (output valid, output abscissa, input ready);
    modport sink   (input valid, input abscissa, output ready);
endinterface

@@ rtl/pev_out_if.sv @@
// ----------------------------------------------------------------------------
// pev_out_if
// Result channel: value, slope, curvature and overflow, valid/ready.
// ----------------------------------------------------------------------------
interface pev_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pev_pkg::COEF_W-1:0]  value;
    logic signed [pev_pkg::COEF_W-1:0]  slope;
    logic signed [pev_pkg::COEF_W-1:0]  curvature;
    logic                               overflow;

    modport source (output valid, output value, output slope, output curvature,
                    output overflow, input ready);
    modport sink   (input valid, input value, input slope, input curvature,
                    input overflow, output ready);
endinterface

@@ rtl/polynomial_eval_with_derivatives.sv @@
// ----------------------------------------------------------------------------
// polynomial_eval_with_derivatives
// Horner evaluation of p(x), p'(x) and p''(x) in signed Q16.16, exact wide
// accumulation, round to nearest (ties up), saturate, overflow flag.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  --------  ---  -------------  --------------------------------------------
//  i_in      in   valid/ready    abscissa (Q16.16)
//  o_out     out  valid/ready    value, slope, curvature (Q16.16), overflow
//  i_cfg_*   in   write enable   index 0 order, 1..6 coeff_0..coeff_5
//
// Flow: one item at a time. The 224-bit accumulator is split into
//   NCHUNK = 7 chunks. Each Horner step is one term load plus one pass of
//   the 33x32 partial-product multiplier over the accumulator chunks.
// Reset: order and coefficients clear to zero, no item held.
// Stalls: the result sits in an output register; a new item is taken while
//   it waits. If it is still not taken when the next item finishes, the
//   sequencer holds in its done state.
//
module polynomial_eval_with_derivatives (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    pev_in_if.sink                                 i_in,
    pev_out_if.source                              o_out,
    input  logic                                   i_cfg_we,
    input  logic [pev_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [pev_pkg::COEF_W-1:0]             i_cfg_data
);

`include "polynomial_eval_with_derivatives_defines.svh"

    // ---------------- configuration ----------------
    logic [pev_pkg::ORD_W-1:0]          r_order;
    logic signed [pev_pkg::COEF_W-1:0]  r_coef [pev_pkg::NUM_COEFFS];
    logic [pev_pkg::CFG_IDX_W-1:0]      w_cfg_ci;

    assign w_cfg_ci = i_cfg_idx - pev_pkg::CFG_COEFF0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= '0;
            for (int i = 0; i < pev_pkg::NUM_COEFFS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pev_pkg::CFG_ORDER) begin
                r_order <= i_cfg_data[pev_pkg::ORD_W-1:0];
            end else if (w_cfg_ci < pev_pkg::CFG_IDX_W'(pev_pkg::NUM_COEFFS)) begin
                r_coef[w_cfg_ci[pev_pkg::CI_W-1:0]] <= $signed(i_cfg_data);
            end
        end
    end

    // order clamped to the coefficients present
    logic [pev_pkg::ORD_W-1:0] w_neff;
    assign w_neff = (r_order > pev_pkg::ORD_W'(pev_pkg::MAX_ORDER)) ?
                    pev_pkg::ORD_W'(pev_pkg::MAX_ORDER) : r_order;

    // ---------------- sequencer state ----------------
    pev_pkg::t_state                    r_state, n_state;
    pev_pkg::t_deriv                    r_d, n_d;           // derivative in work
    logic [pev_pkg::ORD_W-1:0]          r_j, n_j;           // power of last term added
    logic [pev_pkg::K_W-1:0]            r_k, n_k;           // chunk counter
    logic [pev_pkg::ACC_W-1:0]          r_acc, n_acc;       // Horner accumulator
    logic [pev_pkg::ACC_W-1:0]          r_nacc, n_nacc;     // next accumulator
    logic signed [pev_pkg::COEF_W-1:0]  r_x, n_x;
    logic [pev_pkg::COEF_W-1:0]         r_val, n_val;
    logic [pev_pkg::COEF_W-1:0]         r_slp, n_slp;
    logic [pev_pkg::COEF_W-1:0]         r_crv, n_crv;
    logic                               r_ovf, n_ovf;
    logic                               r_out_valid, n_out_valid;
    logic [pev_pkg::COEF_W-1:0]         r_o_val, n_o_val;
    logic [pev_pkg::COEF_W-1:0]         r_o_slp, n_o_slp;
    logic [pev_pkg::COEF_W-1:0]         r_o_crv, n_o_crv;
    logic                               r_o_ovf, n_o_ovf;

    // ---------------- term generation ----------------
    logic [pev_pkg::ORD_W-1:0]          w_m;        // top power of this derivative
    logic [pev_pkg::ORD_W-1:0]          w_pow;      // power of the term to load
    logic [pev_pkg::ORD_W-1:0]          w_diff;
    logic [pev_pkg::ORD_W-1:0]          w_cidx;
    logic signed [pev_pkg::SCOEF_W-1:0] w_scaled;
    logic signed [pev_pkg::ACC_W-1:0]   w_scaled_ext;
    logic [pev_pkg::ACC_W-1:0]          w_term;

    assign w_m    = w_neff - pev_pkg::ORD_W'(r_d);
    assign w_pow  = (r_state == pev_pkg::S_LOAD) ? w_m : (r_j - pev_pkg::ORD_W'(1));
    assign w_diff = w_m - w_pow;
    assign w_cidx = w_pow + pev_pkg::ORD_W'(r_d);
    assign w_scaled     = pev_pkg::scale_coef(r_coef[w_cidx[pev_pkg::CI_W-1:0]], w_pow, r_d);
    assign w_scaled_ext = pev_pkg::ACC_W'(w_scaled);
    // c'_j weighted by 2^(16*(m-j)) so all terms share one binary point
    assign w_term = w_scaled_ext << {w_diff, 4'b0000};

    // ---------------- shared multiplier ----------------
    logic                               w_mac_en;
    logic signed [pev_pkg::PP_W-1:0]    w_pp;
    logic signed [pev_pkg::ACC_W-1:0]   w_pp_ext;
    logic [pev_pkg::ACC_SH_W-1:0]       w_pp_sh;
    logic [pev_pkg::ACC_W-1:0]          w_sum;

    pev_mac u_mac (
        .i_clk   (i_clk),
        .i_en    (w_mac_en),
        .i_chunk (r_acc[pev_pkg::CHUNK_W-1:0]),
        .i_x     (r_x),
        .o_pp    (w_pp)
    );

    // product of chunk k-1 lands at bit 32*(k-1); wrap mod 2^ACC_W is exact
    assign w_pp_ext = pev_pkg::ACC_W'(w_pp);
    assign w_pp_sh  = pev_pkg::ACC_SH_W'((r_k - pev_pkg::K_W'(1)) * pev_pkg::CHUNK_W);
    assign w_sum    = r_nacc + (w_pp_ext << w_pp_sh);

    // ---------------- round, shift, saturate ----------------
    logic [pev_pkg::SH_W-1:0]           w_rsh;
    logic [pev_pkg::ACC_W-1:0]          w_rnd;
    logic [pev_pkg::ACC_W-1:0]          w_racc;
    logic [pev_pkg::ACC_W-1:0]          w_shr;
    logic                               w_fit;
    logic [pev_pkg::COEF_W-1:0]         w_res;

    assign w_rsh  = {w_m, 4'b0000};
    assign w_rnd  = (w_m != '0) ?
                    (pev_pkg::ACC_W'(1'b1) << (w_rsh - pev_pkg::SH_W'(1))) : '0;
    assign w_racc = r_acc + w_rnd;
    assign w_shr  = $signed(w_racc) >>> w_rsh;
    assign w_fit  = (&w_shr[pev_pkg::ACC_W-1:pev_pkg::COEF_W-1]) ||
                    !(|w_shr[pev_pkg::ACC_W-1:pev_pkg::COEF_W-1]);
    assign w_res  = w_fit ? w_shr[pev_pkg::COEF_W-1:0] :
                    (w_shr[pev_pkg::ACC_W-1] ? pev_pkg::SAT_MIN : pev_pkg::SAT_MAX);

    // ---------------- next state and datapath ----------------
    always_comb begin
        n_state     = r_state;
        n_d         = r_d;
        n_j         = r_j;
        n_k         = r_k;
        n_acc       = r_acc;
        n_nacc      = r_nacc;
        n_x         = r_x;
        n_val       = r_val;
        n_slp       = r_slp;
        n_crv       = r_crv;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_o_val     = r_o_val;
        n_o_slp     = r_o_slp;
        n_o_crv     = r_o_crv;
        n_o_ovf     = r_o_ovf;
        w_mac_en    = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pev_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_x     = i_in.abscissa;
                    n_ovf   = 1'b0;
                    n_d     = pev_pkg::D_VALUE;
                    n_state = pev_pkg::S_LOAD;
                end
            end
            pev_pkg::S_LOAD: begin
                if (w_neff < pev_pkg::ORD_W'(r_d)) begin
                    // derivative vanishes below its order
                    case (r_d)
                        pev_pkg::D_VALUE: n_val = '0;
                        pev_pkg::D_SLOPE: n_slp = '0;
                        default:          n_crv = '0;
                    endcase
                    if (r_d == pev_pkg::D_CURV) begin
                        n_state = pev_pkg::S_DONE;
                    end else begin
                        n_d     = r_d + pev_pkg::t_deriv'(1);
                        n_state = pev_pkg::S_LOAD;
                    end
                end else begin
                    n_acc   = w_term;
                    n_j     = w_m;
                    n_state = (w_m == '0) ? pev_pkg::S_ROUND : pev_pkg::S_STEP;
                end
            end
            pev_pkg::S_STEP: begin
                n_nacc  = w_term;
                n_k     = '0;
                n_state = pev_pkg::S_MUL;
            end
            pev_pkg::S_MUL: begin
                if (r_k < pev_pkg::K_W'(pev_pkg::NCHUNK)) begin
                    w_mac_en = 1'b1;
                    n_acc    = r_acc >> pev_pkg::CHUNK_W;
                end
                if (r_k != '0) begin
                    n_nacc = w_sum;
                end
                if (r_k == pev_pkg::K_W'(pev_pkg::NCHUNK)) begin
                    n_acc   = w_sum;
                    n_j     = r_j - pev_pkg::ORD_W'(1);
                    n_state = (r_j == pev_pkg::ORD_W'(1)) ? pev_pkg::S_ROUND
                                                          : pev_pkg::S_STEP;
                end else begin
                    n_k = r_k + pev_pkg::K_W'(1);
                end
            end
            pev_pkg::S_ROUND: begin
                case (r_d)
                    pev_pkg::D_VALUE: n_val = w_res;
                    pev_pkg::D_SLOPE: n_slp = w_res;
                    default:          n_crv = w_res;
                endcase
                n_ovf = r_ovf | !w_fit;
                if (r_d == pev_pkg::D_CURV) begin
                    n_state = pev_pkg::S_DONE;
                end else begin
                    n_d     = r_d + pev_pkg::t_deriv'(1);
                    n_state = pev_pkg::S_LOAD;
                end
            end
            pev_pkg::S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_val     = r_val;
                    n_o_slp     = r_slp;
                    n_o_crv     = r_crv;
                    n_o_ovf     = r_ovf;
                    n_state     = pev_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pev_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pev_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d         <= pev_pkg::D_VALUE;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_d         <= n_d;
            r_j         <= n_j;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_nacc  <= n_nacc;
        r_x     <= n_x;
        r_val   <= n_val;
        r_slp   <= n_slp;
        r_crv   <= n_crv;
        r_ovf   <= n_ovf;
        r_o_val <= n_o_val;
        r_o_slp <= n_o_slp;
        r_o_crv <= n_o_crv;
        r_o_ovf <= n_o_ovf;
    end

    // ---------------- ports ----------------
    assign i_in.ready      = (r_state == pev_pkg::S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.value     = $signed(r_o_val);
    assign o_out.slope     = $signed(r_o_slp);
    assign o_out.curvature = $signed(r_o_crv);
    assign o_out.overflow  = r_o_ovf;

    // ---------------- assertions ----------------
    `PEV_CHECK_NEXT(a_accept_starts_value, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == pev_pkg::S_LOAD && r_d == pev_pkg::D_VALUE)
    `PEV_CHECK_IMP(a_round_after_last_term, i_clk, i_rst_n, r_state == pev_pkg::S_ROUND, r_j == '0)
    `PEV_CHECK_IMP(a_chunk_count_bound, i_clk, i_rst_n, r_state == pev_pkg::S_MUL, r_k <= pev_pkg::K_W'(pev_pkg::NCHUNK))
    `PEV_CHECK_IMP(a_overflow_has_sat, i_clk, i_rst_n, o_out.valid && o_out.overflow, r_o_val == pev_pkg::SAT_MAX || r_o_val == pev_pkg::SAT_MIN || r_o_slp == pev_pkg::SAT_MAX || r_o_slp == pev_pkg::SAT_MIN || r_o_crv == pev_pkg::SAT_MAX || r_o_crv == pev_pkg::SAT_MIN)
    `PEV_CHECK_IMP(a_low_order_no_curv, i_clk, i_rst_n, o_out.valid && w_neff < pev_pkg::ORD_W'(2), r_o_crv == '0)

endmodule

@@ rtl/pev_mac.sv @@
// ----------------------------------------------------------------------------
// pev_mac
// Shared partial-product unit: unsigned accumulator chunk times signed x,
// registered.
// ----------------------------------------------------------------------------
module pev_mac (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [pev_pkg::CHUNK_W-1:0]          i_chunk,
    input  logic signed [pev_pkg::COEF_W-1:0]    i_x,
    output logic signed [pev_pkg::PP_W-1:0]      o_pp
);

    logic signed [pev_pkg::CHUNK_W:0]   w_a;
    logic signed [pev_pkg::PP_W-1:0]    w_prod;
    logic signed [pev_pkg::PP_W-1:0]    r_pp;

    assign w_a    = $signed({1'b0, i_chunk});
    assign w_prod = w_a * i_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp <= w_prod;
        end
    end

    assign o_pp = r_pp;

endmodule

@@ dv/tb_polynomial_eval_with_derivatives.sv @@
// ----------------------------------------------------------------------------
// tb_polynomial_eval_with_derivatives
// Self-checking bench for the Horner evaluator with derivatives. A directed
// table covers reset values, rounding ties, saturation, low and clamped
// orders and a dead register index. Random phases with new settings follow.
// Each result is compared with a hand-written value or with a bit-exact wide-integer model of p, p', p''.
// ----------------------------------------------------------------------------
module tb_polynomial_eval_with_derivatives;
    timeunit 1ns;
    timeprecision 1ps;

    import pev_pkg::*;

    // accumulator wide enough for c5 * 20 * x^5 with no wrap
    localparam int WIDE_W          = 256;
    localparam int WATCHDOG_LIMIT  = 4000;   // cycles with no item moving
    localparam int TAIL_CYCLES     = 150;    // one order-5 item plus margin
    localparam int HOLD_OFF_CYCLES = 600;    // long receiver stall, fills the block
    localparam int HOLD_OFF_AFTER  = 150;    // results seen before the long stall
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 100;

    localparam logic [CFG_IDX_W-1:0] REG_C0  = CFG_COEFF0;
    localparam logic [CFG_IDX_W-1:0] REG_C1  = CFG_COEFF0 + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C2  = CFG_COEFF0 + 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C3  = CFG_COEFF0 + 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C4  = CFG_COEFF0 + 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C5  = CFG_COEFF0 + 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BAD = 3'd7;   // past the register list

    localparam logic signed [WIDE_W-1:0] Q_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] Q_MIN    = 32'sh8000_0000;
    localparam logic signed [WIDE_W-1:0] WIDE_ONE = 1;

    typedef struct packed {
        logic signed [COEF_W-1:0] value;
        logic signed [COEF_W-1:0] slope;
        logic signed [COEF_W-1:0] curvature;
        logic                     overflow;
    } poly_result_t;

    localparam poly_result_t ALL_ZERO = '0;

    // one row: either a register write or an item (word = abscissa)
    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [COEF_W-1:0]    word;
        bit                   typed;      // want holds a hand-written result
        poly_result_t         want;
    } stim_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    pev_in_if  in_ch ();
    pev_out_if out_ch ();

    polynomial_eval_with_derivatives uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the block's registers
    logic [ORD_W-1:0]         order_q;
    logic signed [COEF_W-1:0] coef_q [NUM_COEFFS];

    poly_result_t pending_results [$];
    int           mismatch_count;
    int           results_seen;
    int           idle_cycles;

    // ------------------------------------------------------------------------
    // Directed table. Hand-written results only where obvious; the rest goes
    // through the model.
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [$] = '{
        // registers at reset: everything zero
        '{1'b0, '0, 32'h1234_5678, 1'b1, ALL_ZERO},
        '{1'b0, '0, 32'h8000_0000, 1'b1, ALL_ZERO},
        // order 0: value is c0 whatever x, no derivatives, no overflow
        '{1'b1, REG_C0, 32'h7FFF_FFFF, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h7FFF_FFFF, 1'b1, '{SAT_MAX, '0, '0, 1'b0}},
        '{1'b1, REG_C0, 32'h8000_0000, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h0000_0000, 1'b1, '{SAT_MIN, '0, '0, 1'b0}},
        // order 1, c1 = one LSB: exact half steps round toward plus infinity
        '{1'b1, CFG_ORDER, 32'h0000_0001, 1'b0, ALL_ZERO},
        '{1'b1, REG_C0, 32'h0000_0000, 1'b0, ALL_ZERO},
        '{1'b1, REG_C1, 32'h0000_0001, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h0000_8000, 1'b1, '{32'sh1, 32'sh1, '0, 1'b0}},
        '{1'b0, '0, 32'hFFFF_8000, 1'b1, '{32'sh0, 32'sh1, '0, 1'b0}},
        '{1'b0, '0, 32'h0000_7FFF, 1'b1, '{32'sh0, 32'sh1, '0, 1'b0}},
        // saturation both ways
        '{1'b1, REG_C1, 32'h7FFF_FFFF, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h7FFF_FFFF, 1'b1, '{SAT_MAX, SAT_MAX, '0, 1'b1}},
        '{1'b0, '0, 32'h8000_0000, 1'b1, '{SAT_MIN, SAT_MAX, '0, 1'b1}},
        '{1'b1, REG_C1, 32'h8000_0000, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h7FFF_FFFF, 1'b1, '{SAT_MIN, SAT_MIN, '0, 1'b1}},
        // x^2 at x = 2.0: 4.0, 4.0, 2.0
        '{1'b1, CFG_ORDER, 32'h0000_0002, 1'b0, ALL_ZERO},
        '{1'b1, REG_C1, 32'h0000_0000, 1'b0, ALL_ZERO},
        '{1'b1, REG_C2, 32'h0001_0000, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h0002_0000, 1'b1,
          '{32'sh0004_0000, 32'sh0004_0000, 32'sh0002_0000, 1'b0}},
        // full order with mixed coefficients, extreme abscissas
        '{1'b1, CFG_ORDER, 32'h0000_0005, 1'b0, ALL_ZERO},
        '{1'b1, REG_C0, 32'hFFFF_0000, 1'b0, ALL_ZERO},
        '{1'b1, REG_C1, 32'h0000_8000, 1'b0, ALL_ZERO},
        '{1'b1, REG_C2, 32'hFFFE_0000, 1'b0, ALL_ZERO},
        '{1'b1, REG_C3, 32'h0000_4000, 1'b0, ALL_ZERO},
        '{1'b1, REG_C4, 32'h8000_0000, 1'b0, ALL_ZERO},
        '{1'b1, REG_C5, 32'h7FFF_FFFF, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h0000_0000, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h0000_0001, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'hFFFF_FFFF, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h0001_0000, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'hFFFF_0000, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h7FFF_FFFF, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h8000_0000, 1'b0, ALL_ZERO},
        // orders 6 and 7 clamp to the top order
        '{1'b1, CFG_ORDER, 32'h0000_0006, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h0001_8000, 1'b0, ALL_ZERO},
        '{1'b1, CFG_ORDER, 32'hFFFF_FFFF, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'hFFFE_8000, 1'b0, ALL_ZERO},
        // write past the register list must change nothing
        '{1'b1, REG_BAD, 32'hDEAD_BEEF, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h0000_C000, 1'b0, ALL_ZERO},
        '{1'b1, CFG_ORDER, 32'h0000_0003, 1'b0, ALL_ZERO},
        '{1'b0, '0, 32'h0003_0000, 1'b0, ALL_ZERO}
    };

    // ------------------------------------------------------------------------
    // Model: exact Horner sum in a wide signed integer, one rounding, then
    // saturation. Coefficient j lines up with FRAC_W*(m-j) extra bits.
    // ------------------------------------------------------------------------
    function automatic logic signed [WIDE_W-1:0] scaled_coef(input int j, input t_deriv d);
        logic signed [WIDE_W-1:0] c;
        int                       f;
        c = coef_q[j + int'(d)];
        f = (d == D_CURV) ? (j + 2) * (j + 1) : (d == D_SLOPE) ? j + 1 : 1;
        return c * f;
    endfunction

    // {saturated, Q16.16 bits}
    function automatic logic [COEF_W:0] horner_term(input t_deriv d,
                                                    input logic signed [COEF_W-1:0] x);
        logic signed [WIDE_W-1:0] acc;
        int                       n;
        int                       m;
        int                       j;
        n = (int'(order_q) > MAX_ORDER) ? MAX_ORDER : int'(order_q);
        if (n < int'(d))
            return '0;
        m = n - int'(d);
        acc = scaled_coef(m, d);
        for (j = m - 1; j >= 0; j--)
            acc = acc * x + (scaled_coef(j, d) <<< (FRAC_W * (m - j)));
        // half an output LSB, so the floor shift rounds ties upward
        if (m > 0)
            acc = acc + (WIDE_ONE <<< (FRAC_W * m - 1));
        acc = acc >>> (FRAC_W * m);
        if (acc > Q_MAX)
            return {1'b1, SAT_MAX};
        if (acc < Q_MIN)
            return {1'b1, SAT_MIN};
        return {1'b0, acc[COEF_W-1:0]};
    endfunction

    function automatic poly_result_t predict_result(input logic signed [COEF_W-1:0] x);
        logic [COEF_W:0] v;
        logic [COEF_W:0] s;
        logic [COEF_W:0] c;
        poly_result_t    r;
        v = horner_term(D_VALUE, x);
        s = horner_term(D_SLOPE, x);
        c = horner_term(D_CURV, x);
        r.value     = v[COEF_W-1:0];
        r.slope     = s[COEF_W-1:0];
        r.curvature = c[COEF_W-1:0];
        r.overflow  = v[COEF_W] | s[COEF_W] | c[COEF_W];
        return r;
    endfunction

    // mostly values within +/-2.0, some full range, some rails, some near zero
    function automatic logic [COEF_W-1:0] rand_q16();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
            3:       return $urandom_range(0, 2) - 32'd1;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. Inputs move on the falling edge, handshakes are seen on the
    // rising edge.
    // ------------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        if (idx == CFG_ORDER)
            order_q = data[ORD_W-1:0];
        else if (int'(idx) - int'(CFG_COEFF0) < NUM_COEFFS)
            coef_q[int'(idx) - int'(CFG_COEFF0)] = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // valid stays high on return so the next item can follow back to back
    task automatic offer_abscissa(input logic [COEF_W-1:0] x, input bit typed,
                                  input poly_result_t want);
        @(negedge i_clk);
        in_ch.valid    = 1'b1;
        in_ch.abscissa = x;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        pending_results.push_back(typed ? want : predict_result(x));
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge i_clk);
        in_ch.valid    = 1'b0;
        in_ch.abscissa = $urandom;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // registers may only change with nothing in flight
    task automatic settle_block();
        pause_sender(1);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [COEF_W-1:0] exp_v,
                               input logic [COEF_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        poly_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %h %h %h %b",
                         $time, out_ch.value, out_ch.slope, out_ch.curvature,
                         out_ch.overflow);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("value", want.value, out_ch.value);
                check_field("slope", want.slope, out_ch.slope);
                check_field("curvature", want.curvature, out_ch.curvature);
                check_field("overflow", {{(COEF_W-1){1'b0}}, want.overflow},
                            {{(COEF_W-1){1'b0}}, out_ch.overflow});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: segments of always-ready, mostly-ready, half-ready and
    // mostly-stalled, plus one long hold-off once the run is under way so the
    // block backs up and has to drop its input ready.
    // ------------------------------------------------------------------------
    initial begin
        int  seg_len;
        int  mode;
        bit  hold_done;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
                hold_done = 1'b1;
                @(negedge i_clk);
                out_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(8, 120);
            repeat (seg_len) begin
                @(negedge i_clk);
                case (mode)
                    0:       out_ch.ready = 1'b1;
                    1:       out_ch.ready = ($urandom_range(0, 3) != 0);
                    2:       out_ch.ready = ($urandom_range(0, 3) == 0);
                    default: out_ch.ready = $urandom_range(0, 1);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long with no item moving on either channel
    // ------------------------------------------------------------------------
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int  phase;
        int  k;
        int  sent;
        int  burst;
        bit  steady;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.abscissa = '0;
        order_q        = '0;
        foreach (coef_q[i])
            coef_q[i] = '0;
        mismatch_count = 0;
        results_seen   = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write) begin
                settle_block();
                cfg_write(directed_rows[i].reg_idx, directed_rows[i].word);
            end else begin
                offer_abscissa(directed_rows[i].word, directed_rows[i].typed,
                               directed_rows[i].want);
            end
        end

        // random phases: first eight walk orders 0..7, the rest pick one
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle_block();
            cfg_write(CFG_ORDER, (phase < 8) ? phase : $urandom_range(0, 7));
            for (k = 0; k < NUM_COEFFS; k++)
                cfg_write(REG_C0 + k[CFG_IDX_W-1:0], rand_q16());
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_BAD, $urandom);
            steady = ($urandom_range(0, 3) == 0);   // no sender gaps this phase
            sent   = 0;
            while (sent < ITEMS_PER_PHASE) begin
                burst = $urandom_range(1, 12);
                repeat (burst) begin
                    offer_abscissa(rand_q16(), 1'b0, ALL_ZERO);
                    sent++;
                end
                if (!steady && $urandom_range(0, 2) != 0)
                    pause_sender($urandom_range(1, 8));
            end
        end

        // drain, then give the block time to show any stray result
        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
